// File: rtl/core/tlvc_pkg.sv
// Package: shared constants and types for the tolerant lexicographic vector compare.
package tlvc_pkg;

    localparam int VECTOR_LENGTH = 4;
    localparam int ELEMENT_BITS  = 16;
    localparam int TOL_BITS      = 16;
    localparam int CNT_BITS      = 3;
    localparam int MODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam int EXT_BITS = ((ELEMENT_BITS > TOL_BITS) ? ELEMENT_BITS : TOL_BITS) + 1;
    localparam int SUM_BITS = ELEMENT_BITS + $clog2(VECTOR_LENGTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENTS  = CFG_IDX_BITS'(1);

    localparam logic [CNT_BITS-1:0] ELEMENTS_RESET = CNT_BITS'(VECTOR_LENGTH);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LESS    = 3'd0,
        MODE_LE      = 3'd1,
        MODE_GREATER = 3'd2,
        MODE_GE      = 3'd3,
        MODE_EQUAL   = 3'd4
    } t_mode;

    // per-lane relations of lhs against rhs with tolerance
    typedef struct packed {
        logic lt;   // l + t <  r
        logic le;   // l + t <= r
        logic gt;   // l >  r + t
        logic ge;   // l >= r + t
        logic eq;   // l == r
    } t_lane_flags;

endpackage

// File: rtl/core/tlvc_if.sv
// Interfaces: request, response and configuration channels.
interface tlvc_req_if;
    logic                                valid;
    logic                                ready;
    logic [tlvc_pkg::MODE_BITS-1:0]      mode;
    logic                                lhs_infinite;
    logic                                rhs_infinite;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   lhs_elem_0;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   lhs_elem_1;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   lhs_elem_2;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   lhs_elem_3;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   rhs_elem_0;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   rhs_elem_1;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   rhs_elem_2;
    logic [tlvc_pkg::ELEMENT_BITS-1:0]   rhs_elem_3;

    modport source (
        output valid, mode, lhs_infinite, rhs_infinite,
               lhs_elem_0, lhs_elem_1, lhs_elem_2, lhs_elem_3,
               rhs_elem_0, rhs_elem_1, rhs_elem_2, rhs_elem_3,
        input  ready
    );
    modport sink (
        input  valid, mode, lhs_infinite, rhs_infinite,
               lhs_elem_0, lhs_elem_1, lhs_elem_2, lhs_elem_3,
               rhs_elem_0, rhs_elem_1, rhs_elem_2, rhs_elem_3,
        output ready
    );
endinterface

interface tlvc_rsp_if;
    logic valid;
    logic ready;
    logic outcome;

    modport source (output valid, outcome, input ready);
    modport sink (input valid, outcome, output ready);
endinterface

interface tlvc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tlvc_pkg::CFG_IDX_BITS-1:0]    index;
    logic [tlvc_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/tolerant_lex_vector_compare.sv
// Top level: tolerant lexicographic compare of two cost vectors.
//
//  Channel  Dir  Modport  Carries
//  i_req    in   sink     mode, infinity flags, lhs/rhs elements
//  o_rsp    out  source   outcome
//  i_cfg    in   sink     register index, write data (always ready)
//
// One request per cycle until a stalled o_rsp fills the pipe; o_rsp.valid rises
// after the lane compare, merge and output registers (lane loaded at acceptance).
// Stages collapse bubbles; a stalled o_rsp fills the pipe, then i_req.ready drops.
// Synchronous active-low reset clears valid bits; tolerance 0, four elements.
module tolerant_lex_vector_compare (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tlvc_req_if.sink           i_req,
    tlvc_rsp_if.source         o_rsp,
    tlvc_cfg_if.sink           i_cfg
);

    localparam int VL = tlvc_pkg::VECTOR_LENGTH;

    logic [tlvc_pkg::TOL_BITS-1:0]     r_tol;
    logic [tlvc_pkg::CNT_BITS-1:0]     r_count;
    logic [tlvc_pkg::CNT_BITS-1:0]     w_count;

    logic [tlvc_pkg::ELEMENT_BITS-1:0] w_lhs [VL];
    logic [tlvc_pkg::ELEMENT_BITS-1:0] w_rhs [VL];
    logic [tlvc_pkg::ELEMENT_BITS-1:0] w_lane_lhs [VL];
    logic [tlvc_pkg::ELEMENT_BITS-1:0] w_lane_rhs [VL];
    tlvc_pkg::t_lane_flags             w_flags [VL];

    logic [tlvc_pkg::MODE_BITS-1:0]    r_mode;
    logic                              r_linf;
    logic                              r_rinf;

    logic r_v1;
    logic r_v2;
    logic r_ovalid;
    logic r_outcome;
    logic w_outcome;
    logic w_ready1;
    logic w_ready2;
    logic w_ready3;
    logic w_accept;
    logic w_load2;
    logic w_load3;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= '0;
            r_count <= tlvc_pkg::ELEMENTS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tlvc_pkg::REG_TOLERANCE: r_tol   <= i_cfg.data[tlvc_pkg::TOL_BITS-1:0];
                tlvc_pkg::REG_ELEMENTS:  r_count <= i_cfg.data[tlvc_pkg::CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_count = (r_count > tlvc_pkg::CNT_BITS'(VL)) ? tlvc_pkg::CNT_BITS'(VL) : r_count;

    // handshake
    assign w_ready3 = !r_ovalid | o_rsp.ready;
    assign w_ready2 = !r_v2 | w_ready3;
    assign w_ready1 = !r_v1 | w_ready2;
    assign w_accept = i_req.valid & w_ready1;
    assign w_load2  = r_v1 & w_ready2;
    assign w_load3  = r_v2 & w_ready3;

    assign i_req.ready = w_ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_v1     <= w_accept | (r_v1 & !w_ready2);
            r_v2     <= w_load2 | (r_v2 & !w_ready3);
            r_ovalid <= w_load3 | (r_ovalid & !o_rsp.ready);
        end
    end

    // stage 1: lanes
    assign w_lhs[0] = i_req.lhs_elem_0;
    assign w_lhs[1] = i_req.lhs_elem_1;
    assign w_lhs[2] = i_req.lhs_elem_2;
    assign w_lhs[3] = i_req.lhs_elem_3;
    assign w_rhs[0] = i_req.rhs_elem_0;
    assign w_rhs[1] = i_req.rhs_elem_1;
    assign w_rhs[2] = i_req.rhs_elem_2;
    assign w_rhs[3] = i_req.rhs_elem_3;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_linf <= i_req.lhs_infinite;
            r_rinf <= i_req.rhs_infinite;
        end
    end

    for (genvar g = 0; g < VL; g++) begin : g_lane
        tlvc_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (w_accept),
            .i_active (tlvc_pkg::CNT_BITS'(g) < w_count),
            .i_tol    (r_tol),
            .i_lhs    (w_lhs[g]),
            .i_rhs    (w_rhs[g]),
            .o_flags  (w_flags[g]),
            .o_lhs    (w_lane_lhs[g]),
            .o_rhs    (w_lane_rhs[g])
        );
    end

    // stage 2: merge
    tlvc_merge u_merge (
        .i_clk     (i_clk),
        .i_load    (w_load2),
        .i_mode    (r_mode),
        .i_lhs_inf (r_linf),
        .i_rhs_inf (r_rinf),
        .i_flags   (w_flags),
        .i_lhs     (w_lane_lhs),
        .i_rhs     (w_lane_rhs),
        .o_outcome (w_outcome)
    );

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (w_load3) begin
            r_outcome <= w_outcome;
        end
    end

    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.outcome = r_outcome;

endmodule

// File: rtl/core/tlvc_lane.sv
// Lane: registered tolerance compare of one element pair.
module tlvc_lane (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_active,
    input  logic [tlvc_pkg::TOL_BITS-1:0]       i_tol,
    input  logic [tlvc_pkg::ELEMENT_BITS-1:0]   i_lhs,
    input  logic [tlvc_pkg::ELEMENT_BITS-1:0]   i_rhs,
    output tlvc_pkg::t_lane_flags               o_flags,
    output logic [tlvc_pkg::ELEMENT_BITS-1:0]   o_lhs,
    output logic [tlvc_pkg::ELEMENT_BITS-1:0]   o_rhs
);

    logic [tlvc_pkg::EXT_BITS-1:0] w_lhs_x;
    logic [tlvc_pkg::EXT_BITS-1:0] w_rhs_x;
    logic [tlvc_pkg::EXT_BITS-1:0] w_lhs_t;
    logic [tlvc_pkg::EXT_BITS-1:0] w_rhs_t;
    tlvc_pkg::t_lane_flags         n_flags;
    tlvc_pkg::t_lane_flags         r_flags;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] r_lhs;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] r_rhs;

    assign w_lhs_x = tlvc_pkg::EXT_BITS'(i_lhs);
    assign w_rhs_x = tlvc_pkg::EXT_BITS'(i_rhs);
    assign w_lhs_t = w_lhs_x + tlvc_pkg::EXT_BITS'(i_tol);
    assign w_rhs_t = w_rhs_x + tlvc_pkg::EXT_BITS'(i_tol);

    always_comb begin
        if (i_active) begin
            n_flags.lt = w_lhs_t <  w_rhs_x;
            n_flags.le = w_lhs_t <= w_rhs_x;
            n_flags.gt = w_lhs_x >  w_rhs_t;
            n_flags.ge = w_lhs_x >= w_rhs_t;
            n_flags.eq = i_lhs == i_rhs;
        end else begin
            // unused lane: never decides, counts as equal
            n_flags    = '0;
            n_flags.eq = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= n_flags;
            r_lhs   <= i_active ? i_lhs : '0;
            r_rhs   <= i_active ? i_rhs : '0;
        end
    end

    assign o_flags = r_flags;
    assign o_lhs   = r_lhs;
    assign o_rhs   = r_rhs;

endmodule

// File: rtl/core/tlvc_merge.sv
// Merge: first deciding lane, sums and maxima, then the mode's outcome.
module tlvc_merge (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [tlvc_pkg::MODE_BITS-1:0]      i_mode,
    input  logic                                i_lhs_inf,
    input  logic                                i_rhs_inf,
    input  tlvc_pkg::t_lane_flags               i_flags [tlvc_pkg::VECTOR_LENGTH],
    input  logic [tlvc_pkg::ELEMENT_BITS-1:0]   i_lhs [tlvc_pkg::VECTOR_LENGTH],
    input  logic [tlvc_pkg::ELEMENT_BITS-1:0]   i_rhs [tlvc_pkg::VECTOR_LENGTH],
    output logic                                o_outcome
);

    logic                              w_hit_t [tlvc_pkg::VECTOR_LENGTH];
    logic                              w_hit_f [tlvc_pkg::VECTOR_LENGTH];
    logic                              n_same;
    logic                              n_found;
    logic                              n_val;
    logic [tlvc_pkg::SUM_BITS-1:0]     n_suml;
    logic [tlvc_pkg::SUM_BITS-1:0]     n_sumr;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] n_maxl;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] n_maxr;

    tlvc_pkg::t_mode                   r_mode;
    logic                              r_linf;
    logic                              r_rinf;
    logic                              r_same;
    logic                              r_found;
    logic                              r_val;
    logic [tlvc_pkg::SUM_BITS-1:0]     r_suml;
    logic [tlvc_pkg::SUM_BITS-1:0]     r_sumr;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] r_maxl;
    logic [tlvc_pkg::ELEMENT_BITS-1:0] r_maxr;

    always_comb begin
        for (int i = 0; i < tlvc_pkg::VECTOR_LENGTH; i++) begin
            unique case (tlvc_pkg::t_mode'(i_mode))
                tlvc_pkg::MODE_LESS: begin
                    w_hit_t[i] = i_flags[i].lt;
                    w_hit_f[i] = i_flags[i].gt;
                end
                tlvc_pkg::MODE_LE: begin
                    w_hit_t[i] = i_flags[i].le;
                    w_hit_f[i] = i_flags[i].ge;
                end
                tlvc_pkg::MODE_GREATER: begin
                    w_hit_t[i] = i_flags[i].ge;
                    w_hit_f[i] = i_flags[i].le;
                end
                tlvc_pkg::MODE_GE: begin
                    w_hit_t[i] = i_flags[i].gt;
                    w_hit_f[i] = i_flags[i].lt;
                end
                default: begin
                    w_hit_t[i] = 1'b0;
                    w_hit_f[i] = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_same  = 1'b1;
        n_found = 1'b0;
        n_val   = 1'b0;
        n_suml  = '0;
        n_sumr  = '0;
        n_maxl  = '0;
        n_maxr  = '0;
        for (int i = 0; i < tlvc_pkg::VECTOR_LENGTH; i++) begin
            n_same = n_same & i_flags[i].eq;
            n_suml = n_suml + tlvc_pkg::SUM_BITS'(i_lhs[i]);
            n_sumr = n_sumr + tlvc_pkg::SUM_BITS'(i_rhs[i]);
            if (i_lhs[i] > n_maxl) begin
                n_maxl = i_lhs[i];
            end
            if (i_rhs[i] > n_maxr) begin
                n_maxr = i_rhs[i];
            end
        end
        // lowest deciding lane wins
        for (int i = tlvc_pkg::VECTOR_LENGTH - 1; i >= 0; i--) begin
            if (w_hit_t[i] | w_hit_f[i]) begin
                n_found = 1'b1;
                n_val   = w_hit_t[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mode  <= tlvc_pkg::t_mode'(i_mode);
            r_linf  <= i_lhs_inf;
            r_rinf  <= i_rhs_inf;
            r_same  <= n_same;
            r_found <= n_found;
            r_val   <= n_val;
            r_suml  <= n_suml;
            r_sumr  <= n_sumr;
            r_maxl  <= n_maxl;
            r_maxr  <= n_maxr;
        end
    end

    always_comb begin
        unique case (r_mode)
            tlvc_pkg::MODE_LESS: begin
                priority if (r_rinf)  o_outcome = !r_linf;
                else if (r_linf)      o_outcome = 1'b0;
                else if (r_found)     o_outcome = r_val;
                else                  o_outcome = r_suml < r_sumr;
            end
            tlvc_pkg::MODE_LE: begin
                priority if (r_rinf)  o_outcome = 1'b1;
                else if (r_linf)      o_outcome = 1'b0;
                else if (r_same)      o_outcome = 1'b1;
                else if (r_found)     o_outcome = r_val;
                else                  o_outcome = r_maxl <= r_maxr;
            end
            tlvc_pkg::MODE_GREATER: begin
                priority if (r_rinf)  o_outcome = 1'b0;
                else if (r_linf)      o_outcome = 1'b1;
                else if (r_found)     o_outcome = r_val;
                else                  o_outcome = r_suml > r_sumr;
            end
            tlvc_pkg::MODE_GE: begin
                priority if (r_linf)  o_outcome = 1'b1;
                else if (r_rinf)      o_outcome = 1'b0;
                else if (r_same)      o_outcome = 1'b1;
                else if (r_found)     o_outcome = r_val;
                else                  o_outcome = r_suml >= r_sumr;
            end
            tlvc_pkg::MODE_EQUAL: begin
                if (r_linf | r_rinf)  o_outcome = r_linf & r_rinf;
                else                  o_outcome = r_same;
            end
            default: begin
                o_outcome = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/tlvc_checker.sv
// Checker: port-level assertions on the compare block, bound to the top level.
module tlvc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_outcome
);

    logic [1:0] r_inflight;
    logic       w_in;
    logic       w_out;

    assign w_in  = i_req_valid & i_req_ready;
    assign w_out = i_rsp_valid & i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in & !w_out) begin
            r_inflight <= r_inflight + 2'd1;
        end else if (!w_in & w_out) begin
            r_inflight <= r_inflight - 2'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid & !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rsp_valid || !i_rst_n)
        i_rsp_valid & !i_rsp_ready |=> $stable(i_rsp_outcome))
        else $error("outcome changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_inflight != 2'd0) || $past(w_in))
        else $error("response without outstanding request");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid & (r_inflight == 2'd3))
        else $error("request stalled with room in the pipe");

endmodule

bind tolerant_lex_vector_compare tlvc_checker u_tlvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_outcome (o_rsp.outcome)
);
